>>> design/assert_macros.svh
// Assertion macros shared by the upwind face value modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/vlf_pkg.sv
// Package: widths, sequencer states, divider bundles and saturation helpers
package vlf_pkg;

  // Fixed point format of all data fields
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned IN_DATA_W = 3 * DATA_W;

  // Shared divider: quotient known to fit QUOT_W bits
  localparam int unsigned QUOT_W = DATA_W;
  localparam int unsigned DEND_W = 2 * QUOT_W;
  localparam int unsigned DIVR_W = DATA_W + 1;
  localparam int unsigned CNT_W  = $clog2(QUOT_W + 1);

  // Magnitudes fed to saturation and product widths
  localparam int unsigned MAG_W      = 2 * DATA_W;
  localparam int unsigned SHW        = DATA_W + FRAC_W;
  localparam int unsigned TERM_SHIFT = FRAC_W + 1;
  localparam int unsigned TERM_W     = MAG_W - TERM_SHIFT;
  localparam int unsigned FACE_W     = TERM_W + 2;

  // Cells seen in the current column
  localparam logic [1:0] CS_NONE = 2'd0;
  localparam logic [1:0] CS_ONE  = 2'd1;
  localparam logic [1:0] CS_TWO  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QDIV,
    ST_QWAIT,
    ST_HM_MUL,
    ST_HM_DIV,
    ST_HM_WAIT,
    ST_FACE_MUL,
    ST_FACE_SUM,
    ST_COMMIT
  } vlf_state_e;

  typedef struct packed {
    logic              start;
    logic [DEND_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              clip;
    logic [DATA_W-1:0] value;
  } sat_t;

  // Signed value from sign and magnitude, clipped to DATA_W bits
  function automatic sat_t sat_from_mag(input logic neg, input logic [MAG_W-1:0] mag);
    sat_t              r;
    logic [MAG_W-1:0]  lim_neg;
    logic [MAG_W-1:0]  lim_pos;
    lim_neg = MAG_W'(1) << (DATA_W - 1);
    lim_pos = lim_neg - MAG_W'(1);
    r.clip  = 1'b0;
    if (neg) begin
      if (mag > lim_neg) begin
        r.clip  = 1'b1;
        r.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        r.value = DATA_W'(0) - mag[DATA_W-1:0];
      end
    end else begin
      if (mag > lim_pos) begin
        r.clip  = 1'b1;
        r.value = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        r.value = mag[DATA_W-1:0];
      end
    end
    return r;
  endfunction

  // Magnitude of a two's complement DATA_W value
  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (DATA_W'(0) - x) : x;
  endfunction

endpackage

>>> design/van_leer_upwind_face_value_unit.sv
// Top level: van Leer limited upwind face value over a radial column of cells
// Cells arrive in column order; the first two cells of a column are taken
// and give no word out. Every later cell gives one face value for the cell
// before it, and no further cell is taken until its work is done: three
// passes through the one shared 32-step restoring divider (the two one-sided
// slopes and the harmonic mean) plus the shared 32x32 multiplier and the
// saturation steps. A slope whose difference is zero, whose width is zero or
// whose quotient overflows skips its divider pass, and a limited slope of
// zero skips the third. The result sits in an output register, so the next
// cell is taken while it waits; if it is still not taken when the next result
// is ready, the block holds in its last step.
`include "assert_macros.svh"

module van_leer_upwind_face_value_unit import vlf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // cell_value, cell_width, velocity
  input  logic                 s_axis_tlast,  // last_in_column
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,  // face_value
  output logic                 m_axis_tuser,  // saturated
  output logic                 m_axis_tlast   // column_end
);

  vlf_state_e state_q, state_d;

  // Captured input word
  logic [DATA_W-1:0] val_in_q, wid_in_q, vel_in_q;
  logic              last_in_q;

  // Column history
  logic [DATA_W-1:0] v2_q, v1_q, w2_q, w1_q, s1_q, vel1_q;
  logic [1:0]        cs_q;

  // Work registers
  logic              idx_q;
  logic              neg_q;
  logic [DATA_W-1:0] dm_q, dp_q, slope_q, base_q;
  logic [DIVR_W-1:0] sum_q;
  logic [MAG_W-1:0]  mul_q;
  logic              tneg_q;
  logic [FACE_W-1:0] face_q;
  logic              clip_q;

  // Output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_face_q;
  logic              out_sat_q;
  logic              out_last_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic out_free;

  // One-sided difference and width for the current slope
  logic [DATA_W-1:0] num_a, num_b, qw;
  logic [DATA_W:0]   diff, dmag;
  logic              dneg, q_zero, q_over;

  // Limiter and face operands
  logic [DATA_W-1:0] ma, mb;
  logic              hm_zero;
  logic              face_up;
  logic [DATA_W-1:0] fw, fs, fbase;
  logic              fminus;
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [TERM_W-1:0] term;
  logic              fneg;
  logic [FACE_W-1:0] fmag;

  // Control from the sequencer
  logic q_ld, hm_ld, slope_ld, face_ld, sum_ld, out_ld;
  sat_t q_res, slope_res, face_res;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Operands of the left and right difference
  assign num_a  = idx_q ? val_in_q : v1_q;
  assign num_b  = idx_q ? v1_q : v2_q;
  assign qw     = idx_q ? wid_in_q : w1_q;
  assign diff   = {num_a[DATA_W-1], num_a} - {num_b[DATA_W-1], num_b};
  assign dneg   = diff[DATA_W];
  assign dmag   = dneg ? ((DATA_W+1)'(0) - diff) : diff;
  assign q_zero = (dmag == '0);
  assign q_over = (qw == '0) || (SHW'(dmag) >= {qw, {FRAC_W{1'b0}}});

  // Limiter operands
  assign ma      = mag_of(dm_q);
  assign mb      = mag_of(dp_q);
  assign hm_zero = (dm_q == '0) || (dp_q == '0) || (dm_q[DATA_W-1] != dp_q[DATA_W-1]);

  // Upwind choice: cell below with its slope, or this cell with the new slope
  assign face_up = !vel1_q[DATA_W-1] && (vel1_q != '0);
  assign fw      = face_up ? w2_q : w1_q;
  assign fs      = face_up ? s1_q : slope_q;
  assign fbase   = face_up ? v2_q : v1_q;
  assign fminus  = !face_up;

  // Shared multiplier operands
  assign mul_a = (state_q == ST_FACE_MUL) ? fw : ma;
  assign mul_b = (state_q == ST_FACE_MUL) ? mag_of(fs) : mb;

  // Half width times slope, and the face magnitude
  assign term = mul_q[MAG_W-1:TERM_SHIFT];
  assign fneg = face_q[FACE_W-1];
  assign fmag = fneg ? (FACE_W'(0) - face_q) : face_q;

  // Divider requests: one-sided slopes or harmonic mean
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DEND_W'({dmag, {FRAC_W{1'b0}}});
    div_req.divisor  = DIVR_W'(qw);
    if (state_q == ST_HM_DIV) begin
      div_req.dividend = {mul_q[MAG_W-2:0], 1'b0};
      div_req.divisor  = sum_q;
    end
    if ((state_q == ST_QDIV && !q_zero && !q_over) || state_q == ST_HM_DIV) begin
      div_req.start = 1'b1;
    end
  end

  vlf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cs_q == CS_TWO) state_d = ST_QDIV;
      end
      ST_QDIV: begin
        if (q_zero || q_over) state_d = idx_q ? ST_HM_MUL : ST_QDIV;
        else state_d = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (div_rsp.done) state_d = idx_q ? ST_HM_MUL : ST_QDIV;
      end
      ST_HM_MUL: begin
        state_d = hm_zero ? ST_FACE_MUL : ST_HM_DIV;
      end
      ST_HM_DIV:   state_d = ST_HM_WAIT;
      ST_HM_WAIT: begin
        if (div_rsp.done) state_d = ST_FACE_MUL;
      end
      ST_FACE_MUL: state_d = ST_FACE_SUM;
      ST_FACE_SUM: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_ld      = 1'b0;
    hm_ld     = 1'b0;
    sum_ld    = 1'b0;
    slope_ld  = 1'b0;
    face_ld   = 1'b0;
    out_ld    = 1'b0;
    q_res     = '0;
    slope_res = '0;
    face_res  = sat_from_mag(fneg, MAG_W'(fmag));
    unique case (state_q)
      ST_QDIV: begin
        if (q_zero) begin
          q_ld = 1'b1;
        end else if (q_over) begin
          q_ld  = 1'b1;
          q_res = sat_from_mag(dneg, {MAG_W{1'b1}});
        end
      end
      ST_QWAIT: begin
        q_ld  = div_rsp.done;
        q_res = sat_from_mag(neg_q, MAG_W'(div_rsp.quotient));
      end
      ST_HM_MUL: begin
        slope_ld = hm_zero;
        hm_ld    = !hm_zero;
        sum_ld   = !hm_zero;
      end
      ST_HM_WAIT: begin
        slope_ld  = div_rsp.done;
        slope_res = sat_from_mag(dm_q[DATA_W-1], MAG_W'(div_rsp.quotient));
      end
      ST_FACE_MUL: face_ld = 1'b1;
      ST_COMMIT:   out_ld  = out_free;
      default: ;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cs_q        <= CS_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && cs_q != CS_TWO) begin
        cs_q <= s_axis_tlast ? CS_NONE : ((cs_q == CS_NONE) ? CS_ONE : CS_TWO);
      end else if (out_ld && last_in_q) begin
        cs_q <= CS_NONE;
      end
      if (out_ld) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // History registers: reset to zero, advance per cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= '0;
      v1_q   <= '0;
      w2_q   <= '0;
      w1_q   <= '0;
      s1_q   <= '0;
      vel1_q <= '0;
    end else if (in_acc && cs_q != CS_TWO) begin
      v2_q   <= v1_q;
      v1_q   <= s_axis_tdata[DATA_W-1:0];
      w2_q   <= w1_q;
      w1_q   <= s_axis_tdata[2*DATA_W-1:DATA_W];
      vel1_q <= s_axis_tdata[3*DATA_W-1:2*DATA_W];
      if (cs_q == CS_ONE) s1_q <= '0;
    end else if (out_ld) begin
      v2_q   <= v1_q;
      v1_q   <= val_in_q;
      w2_q   <= w1_q;
      w1_q   <= wid_in_q;
      vel1_q <= vel_in_q;
      s1_q   <= slope_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_in_q  <= s_axis_tdata[DATA_W-1:0];
      wid_in_q  <= s_axis_tdata[2*DATA_W-1:DATA_W];
      vel_in_q  <= s_axis_tdata[3*DATA_W-1:2*DATA_W];
      last_in_q <= s_axis_tlast;
      idx_q     <= 1'b0;
      clip_q    <= 1'b0;
    end
    if (div_req.start && state_q == ST_QDIV) neg_q <= dneg;
    if (q_ld) begin
      if (idx_q) dp_q <= q_res.value;
      else dm_q <= q_res.value;
      idx_q  <= 1'b1;
      clip_q <= clip_q | q_res.clip;
    end
    if (hm_ld || face_ld) mul_q <= mul_a * mul_b;
    if (sum_ld) sum_q <= DIVR_W'(ma) + DIVR_W'(mb);
    if (slope_ld) begin
      slope_q <= slope_res.value;
      clip_q  <= clip_q | slope_res.clip;
    end
    if (face_ld) begin
      base_q <= fbase;
      tneg_q <= fs[DATA_W-1] != fminus;
    end
    if (state_q == ST_FACE_SUM) begin
      face_q <= tneg_q ? (FACE_W'($signed(base_q)) - FACE_W'(term))
                       : (FACE_W'($signed(base_q)) + FACE_W'(term));
    end
    if (out_ld) begin
      out_face_q <= face_res.value;
      out_sat_q  <= clip_q | face_res.clip;
      out_last_q <= last_in_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_face_q;
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

  `ASSERT_ALWAYS(a_cells_seen_legal, clk_i, rst_ni, (cs_q == CS_NONE) || (cs_q == CS_ONE) || (cs_q == CS_TWO), "cells seen count out of range")
  `ASSERT_IMPLIES(a_wait_has_divider, clk_i, rst_ni, (state_q == ST_QWAIT) || (state_q == ST_HM_WAIT), div_rsp.busy || div_rsp.done, "waiting on an idle divider")
  `ASSERT_IMPLIES(a_word_from_commit, clk_i, rst_ni, $rose(m_axis_tvalid), $past(state_q) == ST_COMMIT, "output word raised outside the commit step")

endmodule

>>> design/vlf_divider.sv
// Shared restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module vlf_divider import vlf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] low_q, low_d;
  logic [DIVR_W-1:0] dvs_q, dvs_d;
  logic [DIVR_W:0]   shifted;
  logic [DIVR_W:0]   trial;
  logic              ge;

  // Trial subtract of the shifted remainder
  assign shifted = {rem_q, low_q[QUOT_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign ge      = !trial[DIVR_W];

  // Load on start, then shift one quotient bit in per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUOT_W);
      rem_d  = DIVR_W'(req_i.dividend[DEND_W-1:QUOT_W]);
      low_d  = req_i.dividend[QUOT_W-1:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
      low_d = {low_q[QUOT_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = low_q;

  `ASSERT_IMPLIES(a_start_when_idle, clk_i, rst_ni, req_i.start, !busy_q, "divider started while busy")
  `ASSERT_IMPLIES(a_done_after_last_step, clk_i, rst_ni, done_q, $past(busy_q) && ($past(cnt_q) == CNT_W'(1)), "divider done without a final step")

endmodule

>>> test/upwind_face_checker.sv
// Checker for the upwind face value unit: predicts each face word and compares it
`timescale 1ns / 1ps

module upwind_face_checker import vlf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // cell_value, cell_width, velocity
  input  logic                 s_axis_tlast,   // last_in_column
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [DATA_W-1:0]    m_axis_tdata,   // face_value
  input  logic                 m_axis_tuser,   // saturated
  input  logic                 m_axis_tlast,   // column_end
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] face_value;
    logic              saturated;
    logic              column_end;
  } face_word_t;

  face_word_t expected_faces[$];
  face_word_t oldest_face;

  // Column history: one and two cells back
  logic signed [DATA_W-1:0] near_value;
  logic signed [DATA_W-1:0] far_value;
  logic        [DATA_W-1:0] near_width;
  logic        [DATA_W-1:0] far_width;
  logic signed [DATA_W-1:0] near_slope;
  logic signed [DATA_W-1:0] near_velocity;
  logic        [1:0]        cells_in_column;

  function automatic longint unsigned magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Clip a sign and magnitude to a DATA_W two's complement word
  function automatic longint saturate_word(input bit neg, input longint unsigned mag,
                                           inout logic clip);
    longint unsigned lim_neg;
    longint unsigned lim_pos;
    lim_neg = 64'd1 << (DATA_W - 1);
    lim_pos = lim_neg - 64'd1;
    if (neg) begin
      if (mag > lim_neg) begin
        mag  = lim_neg;
        clip = 1'b1;
      end
      return -longint'(mag);
    end
    if (mag > lim_pos) begin
      mag  = lim_pos;
      clip = 1'b1;
    end
    return longint'(mag);
  endfunction

  // Difference over a width in Q format, truncated toward zero
  function automatic longint scaled_quotient(input longint diff, input longint unsigned w,
                                             inout logic clip);
    longint unsigned m;
    m = magnitude(diff);
    if (m == 0) return 0;
    if (w == 0) return saturate_word(diff < 0, '1, clip);
    return saturate_word(diff < 0, (m << FRAC_W) / w, clip);
  endfunction

  // Van Leer limiter: harmonic mean of same-signed slopes, else zero
  function automatic longint harmonic_slope(input longint a, input longint b,
                                            inout logic clip);
    longint unsigned ma;
    longint unsigned mb;
    if (a == 0 || b == 0 || ((a < 0) != (b < 0))) return 0;
    ma = magnitude(a);
    mb = magnitude(b);
    return saturate_word(a < 0, (64'd2 * ma * mb) / (ma + mb), clip);
  endfunction

  // Take one cell into the column history, queue the face word it yields
  task automatic advance_column(input logic [IN_DATA_W-1:0] cell_word, input logic last);
    longint          dm;
    longint          dp;
    longint          slope;
    longint          base;
    longint          s;
    longint          face;
    longint unsigned w;
    longint unsigned term;
    logic            minus;
    logic            term_neg;
    logic            clip;
    face_word_t      word;
    if (cells_in_column == CS_TWO) begin
      clip  = 1'b0;
      dm    = scaled_quotient(longint'(near_value) - longint'(far_value),
                              64'(near_width), clip);
      dp    = scaled_quotient(longint'($signed(cell_word[DATA_W-1:0])) - longint'(near_value),
                              64'(cell_word[2*DATA_W-1:DATA_W]), clip);
      slope = harmonic_slope(dm, dp, clip);
      // upwind: extrapolate from the cell below or back from the cell itself
      if (near_velocity > 0) begin
        base  = longint'(far_value);
        w     = 64'(far_width);
        s     = longint'(near_slope);
        minus = 1'b0;
      end else begin
        base  = longint'(near_value);
        w     = 64'(near_width);
        s     = slope;
        minus = 1'b1;
      end
      term     = (w * magnitude(s)) >> (FRAC_W + 1);
      term_neg = (s < 0) != minus;
      face     = term_neg ? base - longint'(term) : base + longint'(term);
      face     = saturate_word(face < 0, magnitude(face), clip);
      word.face_value = face[DATA_W-1:0];
      word.saturated  = clip;
      word.column_end = last;
      expected_faces.push_back(word);
      near_slope = slope[DATA_W-1:0];
    end else if (cells_in_column == CS_ONE) begin
      near_slope      = '0;
      cells_in_column = CS_TWO;
    end else begin
      cells_in_column = CS_ONE;
    end
    far_value     = near_value;
    near_value    = cell_word[DATA_W-1:0];
    far_width     = near_width;
    near_width    = cell_word[2*DATA_W-1:DATA_W];
    near_velocity = cell_word[3*DATA_W-1:2*DATA_W];
    if (last) cells_in_column = CS_NONE;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_faces.delete();
      near_value      = '0;
      far_value       = '0;
      near_width      = '0;
      far_width       = '0;
      near_slope      = '0;
      near_velocity   = '0;
      cells_in_column = CS_NONE;
    end else begin
      // retire the oldest expectation against each accepted face word
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_faces.size() == 0) begin
          $error("face word with none expected: face_value %h", m_axis_tdata);
          errors_o++;
        end else begin
          oldest_face = expected_faces.pop_front();
          if (m_axis_tdata !== oldest_face.face_value) begin
            $error("face_value: expected %h, got %h", oldest_face.face_value, m_axis_tdata);
            errors_o++;
          end
          if (m_axis_tuser !== oldest_face.saturated) begin
            $error("saturated: expected %b, got %b", oldest_face.saturated, m_axis_tuser);
            errors_o++;
          end
          if (m_axis_tlast !== oldest_face.column_end) begin
            $error("column_end: expected %b, got %b", oldest_face.column_end, m_axis_tlast);
            errors_o++;
          end
        end
      end
      // predict from each accepted cell
      if (s_axis_tvalid && s_axis_tready) advance_column(s_axis_tdata, s_axis_tlast);
    end
    pending_o = expected_faces.size();
  end

endmodule

>>> test/van_leer_upwind_face_value_unit_tb.sv
// Testbench top for the upwind face value unit: cell stimulus, handshake idling, verdict
`timescale 1ns / 1ps

module van_leer_upwind_face_value_unit_tb;
  import vlf_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PHASE_CELLS    = 250;
  localparam int HOLD_OFF_CYCLES = 800;
  localparam int DRAIN_CYCLES   = 250;

  localparam logic [DATA_W-1:0] CORNER_VALUE [3] = '{32'h7FFFFFFF, 32'h80000000, 32'h0};
  localparam logic [DATA_W-1:0] CORNER_WIDTH [3] = '{32'h1, 32'hFFFFFFFF, 32'h10000};

  typedef enum int {COL_RANDOM, COL_SMOOTH, COL_RIPPLE, COL_CORNER} column_kind_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;   // cell_value, cell_width, velocity
  logic                 s_axis_tlast;   // last_in_column
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;   // face_value
  logic                 m_axis_tuser;   // saturated
  logic                 m_axis_tlast;   // column_end

  int errors;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  van_leer_upwind_face_value_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  upwind_face_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one cell word, idling first at the sender's rate
  task automatic offer_cell(input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] width,
                            input logic [DATA_W-1:0] velocity, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {velocity, width, value};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Send a whole column of the given length with content of a random kind
  task automatic send_random_column(input int cells);
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] width;
    logic [DATA_W-1:0] velocity;
    column_kind_e      kind;
    int                step;
    kind  = column_kind_e'($urandom_range(3));
    value = $urandom_range(32'h0FFFFFFF) - 32'h08000000;
    step  = int'($urandom_range(32'h40000)) - 32'h20000;
    for (int i = 0; i < cells; i++) begin
      case (kind)
        COL_RANDOM: begin
          value    = $urandom;
          width    = $urandom;
          velocity = $urandom;
        end
        COL_SMOOTH: begin
          value    = value + step + int'($urandom_range(511)) - 256;
          width    = $urandom_range(32'h40000, 32'h4000);
          velocity = $urandom_range(32'h30000) - 32'h18000;
        end
        COL_RIPPLE: begin
          value    = $urandom_range(32'h80000) - 32'h40000;
          width    = $urandom_range(32'h20000, 32'h100);
          velocity = $urandom_range(1) ? 32'h10000 : 32'hFFFF0000;
        end
        default: begin
          value    = ($urandom_range(3) == 0) ? $urandom : CORNER_VALUE[$urandom_range(2)];
          width    = ($urandom_range(3) == 0) ? $urandom : CORNER_WIDTH[$urandom_range(2)];
          velocity = ($urandom_range(3) == 0) ? $urandom : CORNER_VALUE[$urandom_range(2)];
        end
      endcase
      if (width == '0) width = 32'h1;
      offer_cell(value, width, velocity, i == cells - 1);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stop a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("van_leer_upwind_face_value_unit_tb NOT OK");
    $finish;
  end

  initial begin
    int sent;
    int cells;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rising column, positive velocity: harmonic mean of agreeing slopes
    offer_cell(32'h00010000, 32'h00010000, 32'h00008000, 1'b0);
    offer_cell(32'h00020000, 32'h00008000, 32'h00008000, 1'b0);
    offer_cell(32'h00038000, 32'h00020000, 32'h00008000, 1'b0);
    offer_cell(32'h00050000, 32'h00010000, 32'h00008000, 1'b0);
    offer_cell(32'h00060000, 32'h00018000, 32'h00008000, 1'b1);
    // falling column, negative velocity
    offer_cell(32'h00040000, 32'h00010000, 32'hFFFF0000, 1'b0);
    offer_cell(32'h00030000, 32'h00010000, 32'hFFFF0000, 1'b0);
    offer_cell(32'h00018000, 32'h00010000, 32'hFFFF0000, 1'b0);
    offer_cell(32'hFFFE0000, 32'h00010000, 32'hFFFF0000, 1'b1);
    // peak and flat run with zero velocity: limited slope is zero
    offer_cell(32'h00010000, 32'h00010000, 32'h00000000, 1'b0);
    offer_cell(32'h00030000, 32'h00010000, 32'h00000000, 1'b0);
    offer_cell(32'h00010000, 32'h00010000, 32'h00000000, 1'b0);
    offer_cell(32'h00010000, 32'h00010000, 32'h00000000, 1'b1);
    // field extremes: differences clip, tiny and huge widths
    offer_cell(32'h7FFFFFFF, 32'h00000001, 32'h7FFFFFFF, 1'b0);
    offer_cell(32'h80000000, 32'hFFFFFFFF, 32'h80000000, 1'b0);
    offer_cell(32'h7FFFFFFF, 32'h00000001, 32'h7FFFFFFF, 1'b0);
    offer_cell(32'h80000000, 32'h00000001, 32'h7FFFFFFF, 1'b0);
    offer_cell(32'h00000000, 32'hFFFFFFFF, 32'h00000000, 1'b1);
    // face value pushed past the positive limit
    offer_cell(32'h70000000, 32'h00010000, 32'h00010000, 1'b0);
    offer_cell(32'h78000000, 32'h00010000, 32'h00010000, 1'b0);
    offer_cell(32'h7F000000, 32'hFFFFFFFF, 32'h00010000, 1'b0);
    offer_cell(32'h7FFFFFFF, 32'h00000001, 32'h00010000, 1'b0);
    offer_cell(32'h7FFFFFFF, 32'h00010000, 32'h00010000, 1'b1);
    // short columns of one and two cells give no face word
    offer_cell(32'h12345678, 32'h00010000, 32'h00010000, 1'b1);
    offer_cell(32'h00020000, 32'h00010000, 32'hFFFF8000, 1'b0);
    offer_cell(32'h00040000, 32'h00010000, 32'hFFFF8000, 1'b1);

    // random columns over the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      // back up the output so the block fills and stalls its input
      if (phase == 0 || phase == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_CELLS) begin
        cells = ($urandom_range(4) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
        send_random_column(cells);
        sent += cells;
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding face words, then let any late word show up
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("van_leer_upwind_face_value_unit_tb OK");
    end else begin
      $display("van_leer_upwind_face_value_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/vlf_pkg.sv
design/vlf_divider.sv
design/van_leer_upwind_face_value_unit.sv
test/upwind_face_checker.sv
test/van_leer_upwind_face_value_unit_tb.sv
